### rtl/bed_pkg.sv
`default_nettype none

package bed_pkg;

  // Width of the running byte offset and of the reported error offset
  localparam int unsigned PosBits    = 32;
  localparam int unsigned ErrPosBits = 32;

  // Largest reportable error offset, in the width of the running offset
  localparam logic [PosBits-1:0] ErrPosLimit = PosBits'({ErrPosBits{1'b1}});
  localparam logic [PosBits-1:0] PosMax      = {PosBits{1'b1}};

  // Escape characters
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChDigitZero = 8'h30;
  localparam logic [7:0] ChLowerX    = 8'h78;

  // Decoded values of the single-character escapes
  localparam logic [7:0] ByteNewline = 8'h0A;
  localparam logic [7:0] ByteReturn  = 8'h0D;
  localparam logic [7:0] ByteTab     = 8'h09;
  localparam logic [7:0] ByteNul     = 8'h00;

  typedef enum logic [4:0] {
    PH_PLAIN = 5'b00001,
    PH_ESC   = 5'b00010,
    PH_HEX1  = 5'b00100,
    PH_HEX2  = 5'b01000,
    PH_DROP  = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRAILING = 3'd1,
    ST_INCOMPL  = 3'd2,
    ST_BADHEX   = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_e;

  typedef struct packed {
    logic                  valid;
    logic [7:0]            data;
    status_e               status;
    logic                  eos;
    logic [ErrPosBits-1:0] err_pos;
  } bed_result_t;

  // Returns {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/bed_core.sv
`default_nettype none

module bed_core
  import bed_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output bed_result_t res_o
);

  phase_e               phase_q, phase_d;
  logic [3:0]           nibble_q, nibble_d;
  logic [PosBits-1:0]   pos_q, pos_d;
  logic [PosBits-1:0]   esc_q, esc_d;
  logic [4:0]           hex;
  logic                 emit;
  logic [7:0]           data;
  status_e              status;
  logic                 eos;

  always_comb begin
    hex      = hex_decode(byte_i);
    phase_d  = phase_q;
    nibble_d = nibble_q;
    esc_d    = esc_q;
    emit     = 1'b0;
    data     = 8'h00;
    status   = ST_OK;
    eos      = last_i;

    unique case (phase_q)
      PH_PLAIN: begin
        if (byte_i == ChBackslash) begin
          esc_d = pos_q;
          if (last_i) begin
            emit    = 1'b1;
            status  = ST_TRAILING;
            phase_d = PH_DROP;
          end else begin
            phase_d = PH_ESC;
          end
        end else begin
          emit = 1'b1;
          data = byte_i;
        end
      end
      PH_ESC: begin
        phase_d = PH_PLAIN;
        emit    = 1'b1;
        unique case (byte_i)
          ChBackslash: data = ChBackslash;
          ChLowerN:    data = ByteNewline;
          ChLowerR:    data = ByteReturn;
          ChLowerT:    data = ByteTab;
          ChDigitZero: data = ByteNul;
          ChLowerX: begin
            if (last_i) begin
              status  = ST_INCOMPL;
              phase_d = PH_DROP;
            end else begin
              emit    = 1'b0;
              phase_d = PH_HEX1;
            end
          end
          default: begin
            status  = ST_UNKNOWN;
            phase_d = PH_DROP;
          end
        endcase
      end
      PH_HEX1: begin
        // end of string wins over a bad digit
        if (last_i) begin
          emit    = 1'b1;
          status  = ST_INCOMPL;
          phase_d = PH_DROP;
        end else if (!hex[4]) begin
          emit    = 1'b1;
          status  = ST_BADHEX;
          phase_d = PH_DROP;
        end else begin
          nibble_d = hex[3:0];
          phase_d  = PH_HEX2;
        end
      end
      PH_HEX2: begin
        emit = 1'b1;
        if (!hex[4]) begin
          status  = ST_BADHEX;
          phase_d = PH_DROP;
        end else begin
          data    = {nibble_q, hex[3:0]};
          phase_d = PH_PLAIN;
        end
      end
      PH_DROP: begin
      end
      default: begin
        phase_d = PH_PLAIN;
      end
    endcase

    if (status != ST_OK) begin
      eos = 1'b1;
    end

    // a marked byte always closes the string
    if (last_i) begin
      phase_d = PH_PLAIN;
      pos_d   = '0;
    end else if (pos_q != PosMax) begin
      pos_d = pos_q + 1'b1;
    end else begin
      pos_d = pos_q;
    end
  end

  always_comb begin
    res_o.valid   = step_i && emit;
    res_o.data    = data;
    res_o.status  = status;
    res_o.eos     = eos;
    res_o.err_pos = '0;
    if (status != ST_OK) begin
      res_o.err_pos = (esc_d > ErrPosLimit) ? ErrPosBits'(ErrPosLimit) : ErrPosBits'(esc_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_PLAIN;
      nibble_q <= '0;
      pos_q    <= '0;
      esc_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      nibble_q <= nibble_d;
      pos_q    <= pos_d;
      esc_q    <= esc_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> phase_q == PH_PLAIN && pos_q == '0)
    else $error("string end did not restart the decoder");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status != ST_OK |-> res_o.eos && res_o.data == 8'h00)
    else $error("error result without end marker or with data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_DROP |-> !res_o.valid)
    else $error("result while dropping after an error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.status == ST_OK |-> res_o.err_pos == '0)
    else $error("error offset on a good result");

endmodule

`default_nettype wire

### rtl/backslash_escape_decoder.sv
`default_nettype none

// Backslash escape decoder. Decodes an escaped string that arrives one byte
// per transfer, tlast on its final byte. Plain bytes pass through; \\, \n, \r,
// \t, \0 and \xHH each give one byte. A trailing backslash, an incomplete \x,
// a bad hex digit or an unknown escape letter gives one error result (tuser
// nonzero, data zero, tlast set) carrying the offset of the backslash, and
// the rest of the string is dropped up to its tlast. A backslash, an x after
// it and the first hex digit produce no result unless they end the string.
// Throughput is one byte per clock while m_axis_tready_i does not hold the
// result register full; each byte goes from the input register through the
// decode logic, with its escape state register, to the result register.
module backslash_escape_decoder
  import bed_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // in_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] out_byte, [39:8] error_position
  output logic [2:0]  m_axis_tuser_o,   // [2:0] status
  output logic        m_axis_tlast_o    // end_of_string
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        step;
  bed_result_t res;
  logic        out_valid_q;
  bed_result_t out_q;

  // advance the held byte when the result register is free or draining
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  bed_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res.valid;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.err_pos, out_q.data};
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.eos;

endmodule

`default_nettype wire
